[hdl/bis_pkg.sv]
// Shared types and constants of the bilinear image scaler.
// No dependencies; used by every module under hdl/.
package bis_pkg;

    localparam logic REQ_STORE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_RATIO_X    = 3'd4;
    localparam logic [2:0] CFG_RATIO_Y    = 3'd5;

    localparam logic [9:0]  SRC_WIDTH_RST  = 10'd512;
    localparam logic [9:0]  SRC_HEIGHT_RST = 10'd512;
    localparam logic [10:0] DST_WIDTH_RST  = 11'd480;
    localparam logic [10:0] DST_HEIGHT_RST = 11'd640;
    localparam logic [25:0] RATIO_X_RST    = 26'd69905;
    localparam logic [25:0] RATIO_Y_RST    = 26'd52428;

    typedef struct packed {
        logic       req_type;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } req_t;

    typedef struct packed {
        logic [9:0] out_x;
        logic [9:0] out_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_of_range;
    } res_t;

    // one job handed in order from mapping to the frame port
    typedef struct packed {
        logic        compute;
        logic        oor;
        logic        wr_en;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [23:0] pixel;
        logic [16:0] w00;
        logic [16:0] w01;
        logic [16:0] w10;
        logic [16:0] w11;
    } job_t;

    // travels alongside a frame read
    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        logic        oor;
        logic [16:0] weight;
        logic [9:0]  x;
        logic [9:0]  y;
    } tag_t;

    typedef enum logic [3:0] {
        PH_00 = 4'b0001,
        PH_01 = 4'b0010,
        PH_10 = 4'b0100,
        PH_11 = 4'b1000
    } phase_t;

endpackage

[hdl/bis_map.sv]
// Coordinate mapping: Q10.16 scale, clamp to source, weights, frame addresses.
// Two pipeline stages; depends on bis_pkg.
module bis_map #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_DST_SIDE   = 1024,
    localparam int XW  = $clog2(MAX_SRC_WIDTH),
    localparam int YW  = $clog2(MAX_SRC_HEIGHT),
    localparam int AW  = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bis_pkg::req_t       req,
    input  logic [9:0]          src_width,
    input  logic [9:0]          src_height,
    input  logic [10:0]         dst_width,
    input  logic [10:0]         dst_height,
    input  logic [25:0]         ratio_x,
    input  logic [25:0]         ratio_y,
    input  logic                advance,
    output logic                ready,
    output logic                job_valid,
    output bis_pkg::job_t       job,
    output logic [AW-1:0]       row0,
    output logic [AW-1:0]       row1,
    output logic [XW-1:0]       col0,
    output logic [XW-1:0]       col1
);

    localparam int DCL = $clog2(MAX_DST_SIDE + 1);
    localparam int DW  = (DCL > 11) ? DCL : 11;
    localparam int XCL = $clog2(MAX_SRC_WIDTH + 1);
    localparam int LXW = (XCL > 10) ? XCL : 10;
    localparam int YCL = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int LYW = (YCL > 10) ? YCL : 10;

    logic                s1_valid_reg;
    bis_pkg::req_t       s1_req_reg;
    logic                s1_oor_reg;
    logic [35:0]         s1_cx_reg;
    logic [35:0]         s1_cy_reg;

    logic                s2_valid_reg;
    bis_pkg::job_t       s2_job_reg;
    logic [AW-1:0]       s2_row0_reg;
    logic [AW-1:0]       s2_row1_reg;
    logic [XW-1:0]       s2_col0_reg;
    logic [XW-1:0]       s2_col1_reg;

    logic                s2_take;
    logic                s1_move;
    logic [DW-1:0]       dw_lim;
    logic [DW-1:0]       dh_lim;
    logic                oor_now;
    logic [LXW-1:0]      sw_lim;
    logic [LYW-1:0]      sh_lim;
    logic [XW-1:0]       last_x;
    logic [YW-1:0]       last_y;
    logic [19:0]         ix;
    logic [19:0]         iy;
    logic [XW-1:0]       x0;
    logic [XW-1:0]       x1;
    logic [YW-1:0]       y0;
    logic [YW-1:0]       y1;
    logic [XW-1:0]       xa;
    logic [YW-1:0]       ya;
    logic [8:0]          fx;
    logic [8:0]          fy;
    logic [8:0]          gx;
    logic [8:0]          gy;
    logic [17:0]         m00;
    logic [17:0]         m01;
    logic [17:0]         m10;
    logic [17:0]         m11;
    logic                compute;
    logic                st_ok;
    bis_pkg::job_t       job_next;

    assign s2_take = !s2_valid_reg || advance;
    assign s1_move = s1_valid_reg && s2_take;
    assign ready   = !s1_valid_reg || s2_take;

    // stage 1: out-of-range check and Q20.16 products
    assign dw_lim  = (DW'(dst_width) > DW'(MAX_DST_SIDE)) ? DW'(MAX_DST_SIDE) : DW'(dst_width);
    assign dh_lim  = (DW'(dst_height) > DW'(MAX_DST_SIDE)) ? DW'(MAX_DST_SIDE) : DW'(dst_height);
    assign oor_now = (DW'(req.pos_x) >= dw_lim) || (DW'(req.pos_y) >= dh_lim);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (load) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            s1_req_reg <= req;
            s1_oor_reg <= oor_now;
            s1_cx_reg  <= 36'(ratio_x) * 36'(req.pos_x);
            s1_cy_reg  <= 36'(ratio_y) * 36'(req.pos_y);
        end
    end

    // stage 2: clamp, neighbors, weights, row bases
    assign sw_lim = (LXW'(src_width) > LXW'(MAX_SRC_WIDTH)) ?
                    LXW'(MAX_SRC_WIDTH) : LXW'(src_width);
    assign sh_lim = (LYW'(src_height) > LYW'(MAX_SRC_HEIGHT)) ?
                    LYW'(MAX_SRC_HEIGHT) : LYW'(src_height);
    assign last_x = (src_width == '0) ? '0 : XW'(sw_lim - 1'b1);
    assign last_y = (src_height == '0) ? '0 : YW'(sh_lim - 1'b1);

    assign ix = s1_cx_reg[35:16];
    assign iy = s1_cy_reg[35:16];
    assign x0 = (ix > 20'(last_x)) ? last_x : XW'(ix);
    assign y0 = (iy > 20'(last_y)) ? last_y : YW'(iy);
    assign x1 = (x0 == last_x) ? last_x : x0 + 1'b1;
    assign y1 = (y0 == last_y) ? last_y : y0 + 1'b1;

    assign fx  = {1'b0, s1_cx_reg[15:8]};
    assign fy  = {1'b0, s1_cy_reg[15:8]};
    assign gx  = 9'd256 - fx;
    assign gy  = 9'd256 - fy;
    assign m00 = gx * gy;
    assign m01 = gx * fy;
    assign m10 = fx * gy;
    assign m11 = fx * fy;

    assign compute = (s1_req_reg.req_type == bis_pkg::REQ_COMPUTE);
    assign st_ok   = (13'(s1_req_reg.pos_x) < 13'(MAX_SRC_WIDTH)) &&
                     (13'(s1_req_reg.pos_y) < 13'(MAX_SRC_HEIGHT));
    assign xa      = compute ? x0 : XW'(s1_req_reg.pos_x);
    assign ya      = compute ? y0 : YW'(s1_req_reg.pos_y);

    always_comb begin
        job_next         = '0;
        job_next.compute = compute;
        job_next.oor     = s1_oor_reg;
        job_next.wr_en   = st_ok;
        job_next.x       = s1_req_reg.pos_x;
        job_next.y       = s1_req_reg.pos_y;
        job_next.pixel   = {s1_req_reg.in_blue, s1_req_reg.in_green, s1_req_reg.in_red};
        job_next.w00     = m00[16:0];
        job_next.w01     = m01[16:0];
        job_next.w10     = m10[16:0];
        job_next.w11     = m11[16:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_move) begin
            s2_valid_reg <= 1'b1;
        end else if (advance) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_move) begin
            s2_job_reg  <= job_next;
            s2_row0_reg <= AW'(ya) * AW'(MAX_SRC_WIDTH);
            s2_row1_reg <= AW'(y1) * AW'(MAX_SRC_WIDTH);
            s2_col0_reg <= xa;
            s2_col1_reg <= x1;
        end
    end

    assign job_valid = s2_valid_reg;
    assign job       = s2_job_reg;
    assign row0      = s2_row0_reg;
    assign row1      = s2_row1_reg;
    assign col0      = s2_col0_reg;
    assign col1      = s2_col1_reg;

endmodule

[hdl/bis_frame.sv]
// Source frame store: single-port synchronous memory with registered read data.
// Carries the read tag along with the data; depends on bis_pkg.
module bis_frame #(
    parameter int DEPTH = 262144,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [23:0]   wdata,
    input  bis_pkg::tag_t tag_in,
    output logic [23:0]   rdata,
    output bis_pkg::tag_t tag_out
);

    logic [23:0]   mem [DEPTH];
    logic [23:0]   rdata_reg;
    bis_pkg::tag_t tag_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_in;
        end
    end

    assign rdata   = rdata_reg;
    assign tag_out = tag_reg;

endmodule

[hdl/bis_blend.sv]
// Weighted accumulation of the four neighbors and the result register.
// Depends on bis_pkg.
module bis_blend (
    input  logic          clk,
    input  logic          rst_n,
    input  bis_pkg::tag_t tag,
    input  logic [23:0]   rdata,
    output logic          done,
    output bis_pkg::res_t result
);

    logic [23:0]   acc_r_reg;
    logic [23:0]   acc_g_reg;
    logic [23:0]   acc_b_reg;
    logic          done_reg;
    bis_pkg::res_t res_reg;

    logic [23:0]   prod_r;
    logic [23:0]   prod_g;
    logic [23:0]   prod_b;
    logic [23:0]   sum_r;
    logic [23:0]   sum_g;
    logic [23:0]   sum_b;
    bis_pkg::res_t res_next;

    // weights total 65536, so 255 * 65536 bounds every sum
    assign prod_r = tag.oor ? '0 : {7'b0, tag.weight} * {16'b0, rdata[7:0]};
    assign prod_g = tag.oor ? '0 : {7'b0, tag.weight} * {16'b0, rdata[15:8]};
    assign prod_b = tag.oor ? '0 : {7'b0, tag.weight} * {16'b0, rdata[23:16]};
    assign sum_r  = (tag.first ? '0 : acc_r_reg) + prod_r;
    assign sum_g  = (tag.first ? '0 : acc_g_reg) + prod_g;
    assign sum_b  = (tag.first ? '0 : acc_b_reg) + prod_b;

    always_comb begin
        res_next              = '0;
        res_next.out_x        = tag.x;
        res_next.out_y        = tag.y;
        res_next.out_red      = sum_r[23:16];
        res_next.out_green    = sum_g[23:16];
        res_next.out_blue     = sum_b[23:16];
        res_next.out_of_range = tag.oor;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= tag.valid && tag.last;
        end
    end

    always_ff @(posedge clk) begin
        if (tag.valid) begin
            acc_r_reg <= sum_r;
            acc_g_reg <= sum_g;
            acc_b_reg <= sum_b;
        end
        if (tag.valid && tag.last) begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[hdl/bilinear_image_scaler.sv]
// Path: after the two mapping stages an in-range pixel makes four frame reads and an
// out-of-range one a single slot; the frame read and result registers precede the strobe.
// Frame port: each in-range destination pixel takes four neighbor reads on the single
// frame port; stores and out-of-range requests take the port for a single slot.
// Reset: control and configuration registers return to defaults; frame contents stay
// undefined until written. Results are strobed for one cycle and cannot be stalled.
module bilinear_image_scaler #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_DST_SIDE   = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bis_pkg::req_t req,
    output logic          done,
    output bis_pkg::res_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [25:0]   cfg_data
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int AW    = $clog2(DEPTH);

    logic [9:0]       src_width_reg;
    logic [9:0]       src_height_reg;
    logic [10:0]      dst_width_reg;
    logic [10:0]      dst_height_reg;
    logic [25:0]      ratio_x_reg;
    logic [25:0]      ratio_y_reg;

    logic             map_ready;
    logic             job_valid;
    bis_pkg::job_t    job;
    logic [AW-1:0]    row0;
    logic [AW-1:0]    row1;
    logic [XW-1:0]    col0;
    logic [XW-1:0]    col1;

    bis_pkg::phase_t  ph_reg;
    bis_pkg::phase_t  ph_next;
    logic             multi;
    logic             last_beat;
    logic             advance;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [16:0]      weight;
    bis_pkg::tag_t    seq_tag;
    bis_pkg::tag_t    rd_tag;
    logic [23:0]      rd_data;

    assign cfg_ready = 1'b1;
    assign busy      = !map_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            src_width_reg  <= bis_pkg::SRC_WIDTH_RST;
            src_height_reg <= bis_pkg::SRC_HEIGHT_RST;
            dst_width_reg  <= bis_pkg::DST_WIDTH_RST;
            dst_height_reg <= bis_pkg::DST_HEIGHT_RST;
            ratio_x_reg    <= bis_pkg::RATIO_X_RST;
            ratio_y_reg    <= bis_pkg::RATIO_Y_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bis_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[9:0];
                bis_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[9:0];
                bis_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[10:0];
                bis_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_data[10:0];
                bis_pkg::CFG_RATIO_X:    ratio_x_reg    <= cfg_data;
                bis_pkg::CFG_RATIO_Y:    ratio_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    bis_map #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_SIDE   (MAX_DST_SIDE)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (start && map_ready),
        .req        (req),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .dst_width  (dst_width_reg),
        .dst_height (dst_height_reg),
        .ratio_x    (ratio_x_reg),
        .ratio_y    (ratio_y_reg),
        .advance    (advance),
        .ready      (map_ready),
        .job_valid  (job_valid),
        .job        (job),
        .row0       (row0),
        .row1       (row1),
        .col0       (col0),
        .col1       (col1)
    );

    // frame port sequencer: 4 reads per in-range pixel, else one slot
    assign multi     = job_valid && job.compute && !job.oor;
    assign last_beat = !multi || (ph_reg == bis_pkg::PH_11);
    assign advance   = job_valid && last_beat;
    assign mem_we    = job_valid && !job.compute && job.wr_en;
    assign mem_re    = multi;

    always_comb begin
        ph_next  = ph_reg;
        mem_addr = row0 + AW'(col0);
        weight   = job.w00;
        unique case (ph_reg)
            bis_pkg::PH_00: begin
                if (multi) begin
                    ph_next = bis_pkg::PH_01;
                end
            end
            bis_pkg::PH_01: begin
                ph_next  = bis_pkg::PH_10;
                mem_addr = row1 + AW'(col0);
                weight   = job.w01;
            end
            bis_pkg::PH_10: begin
                ph_next  = bis_pkg::PH_11;
                mem_addr = row0 + AW'(col1);
                weight   = job.w10;
            end
            bis_pkg::PH_11: begin
                ph_next  = bis_pkg::PH_00;
                mem_addr = row1 + AW'(col1);
                weight   = job.w11;
            end
            default: ph_next = bis_pkg::PH_00;
        endcase
    end

    always_comb begin
        seq_tag        = '0;
        seq_tag.valid  = job_valid && job.compute;
        seq_tag.first  = (ph_reg == bis_pkg::PH_00);
        seq_tag.last   = last_beat;
        seq_tag.oor    = job.oor;
        seq_tag.weight = weight;
        seq_tag.x      = job.x;
        seq_tag.y      = job.y;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ph_reg <= bis_pkg::PH_00;
        end else begin
            ph_reg <= ph_next;
        end
    end

    bis_frame #(
        .DEPTH (DEPTH)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (mem_we),
        .re      (mem_re),
        .addr    (mem_addr),
        .wdata   (job.pixel),
        .tag_in  (seq_tag),
        .rdata   (rd_data),
        .tag_out (rd_tag)
    );

    bis_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (rd_tag),
        .rdata  (rd_data),
        .done   (done),
        .result (result)
    );

`ifndef NO_ASSERTIONS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("frame write and read in the same cycle");

    a_write_on_phase0: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (ph_reg == bis_pkg::PH_00))
        else $error("frame write outside the first phase");

    a_phase_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg != bis_pkg::PH_00) |-> multi)
        else $error("read phase advanced without an in-range job");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(seq_tag.valid && seq_tag.last, 2))
        else $error("result strobe without a final transfer from the sequencer");
`endif

endmodule

[tb/bilinear_image_scaler_tb.sv]
// Self-checking testbench for bilinear_image_scaler: stores source pixels, requests
// destination pixels and checks each interpolated result against a built-in predictor.
// Depends on hdl/bis_pkg.sv and hdl/bilinear_image_scaler.sv.
`timescale 1ns / 1ps

module bilinear_image_scaler_tb;

    localparam int FRAME_W      = 512;
    localparam int FRAME_H      = 512;
    localparam int DST_MAX      = 1024;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int RATIO_MAX    = 26'h3FFFFFF;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          start     = 1'b0;
    logic          busy;
    bis_pkg::req_t req       = '0;
    logic          done;
    bis_pkg::res_t result;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [25:0]   cfg_data  = '0;

    // register shadow
    logic [9:0]  src_w_reg   = bis_pkg::SRC_WIDTH_RST;
    logic [9:0]  src_h_reg   = bis_pkg::SRC_HEIGHT_RST;
    logic [10:0] dst_w_reg   = bis_pkg::DST_WIDTH_RST;
    logic [10:0] dst_h_reg   = bis_pkg::DST_HEIGHT_RST;
    logic [25:0] ratio_x_reg = bis_pkg::RATIO_X_RST;
    logic [25:0] ratio_y_reg = bis_pkg::RATIO_Y_RST;

    logic [23:0] frame_pix [int];   // source pixels committed by accepted stores
    bit          frame_plan [int];  // source pixels that queued stores will write

    bis_pkg::req_t pending_reqs[$];
    bis_pkg::res_t expected_pixels[$];

    int errors       = 0;
    bit took         = 1'b0;
    bit dense        = 1'b0;
    int gap_left     = 0;
    int stall_cycles = 0;

    bilinear_image_scaler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int eff_size(int v, int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int dst_eff(logic [10:0] v);
        return (v > DST_MAX) ? DST_MAX : int'(v);
    endfunction

    function automatic bit in_dst(logic [9:0] px, logic [9:0] py);
        return (px < dst_eff(dst_w_reg)) && (py < dst_eff(dst_h_reg));
    endfunction

    // Q20.16 source coordinate: clamped base, clamped neighbor, top 8 fraction bits
    function automatic void map_axis(input logic [9:0] pos, input logic [25:0] ratio,
                                     input int size, output int lo, output int hi,
                                     output int frac);
        logic [35:0] c;
        c    = 36'(pos) * 36'(ratio);
        frac = int'(c[15:8]);
        if (c[35:16] > size - 1)
            lo = size - 1;
        else
            lo = int'(c[35:16]);
        hi = (lo + 1 >= size) ? size - 1 : lo + 1;
    endfunction

    function automatic logic [23:0] read_pix(int x, int y);
        return frame_pix.exists(y * FRAME_W + x) ? frame_pix[y * FRAME_W + x] : 24'h0;
    endfunction

    function automatic bis_pkg::res_t predict_pixel(bis_pkg::req_t r);
        bis_pkg::res_t o;
        int            x0, x1, y0, y1, fx, fy, s;
        int            w [4];
        logic [23:0]   p [4];
        o       = '0;
        o.out_x = r.pos_x;
        o.out_y = r.pos_y;
        if (!in_dst(r.pos_x, r.pos_y))
        begin
            o.out_of_range = 1'b1;
            return o;
        end
        map_axis(r.pos_x, ratio_x_reg, eff_size(int'(src_w_reg), FRAME_W), x0, x1, fx);
        map_axis(r.pos_y, ratio_y_reg, eff_size(int'(src_h_reg), FRAME_H), y0, y1, fy);
        p[0] = read_pix(x0, y0);
        p[1] = read_pix(x0, y1);
        p[2] = read_pix(x1, y0);
        p[3] = read_pix(x1, y1);
        w[0] = (256 - fx) * (256 - fy);
        w[1] = (256 - fx) * fy;
        w[2] = fx * (256 - fy);
        w[3] = fx * fy;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = 0;
            for (int k = 0; k < 4; k++)
                s += w[k] * int'(p[k][8*ch +: 8]);
            case (ch)
                0: o.out_red   = 8'(s >> 16);
                1: o.out_green = 8'(s >> 16);
                default: o.out_blue = 8'(s >> 16);
            endcase
        end
        return o;
    endfunction

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (dense || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compare_field(string name, logic [9:0] want, logic [9:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_store(int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        bis_pkg::req_t it;
        it          = '0;
        it.req_type = bis_pkg::REQ_STORE;
        it.pos_x    = 10'(x);
        it.pos_y    = 10'(y);
        it.in_red   = r;
        it.in_green = g;
        it.in_blue  = b;
        pending_reqs.push_back(it);
        if (x < FRAME_W && y < FRAME_H)
            frame_plan[y * FRAME_W + x] = 1'b1;
    endtask

    task automatic fill_pixel(int x, int y);
        if (!frame_plan.exists(y * FRAME_W + x))
            add_store(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // stores any neighbor not yet written, then requests the pixel
    task automatic add_compute(int x, int y);
        bis_pkg::req_t it;
        int            x0, x1, y0, y1, f;
        if (in_dst(10'(x), 10'(y)))
        begin
            map_axis(10'(x), ratio_x_reg, eff_size(int'(src_w_reg), FRAME_W), x0, x1, f);
            map_axis(10'(y), ratio_y_reg, eff_size(int'(src_h_reg), FRAME_H), y0, y1, f);
            fill_pixel(x0, y0);
            fill_pixel(x0, y1);
            fill_pixel(x1, y0);
            fill_pixel(x1, y1);
        end
        it          = '0;
        it.req_type = bis_pkg::REQ_COMPUTE;
        it.pos_x    = 10'(x);
        it.pos_y    = 10'(y);
        pending_reqs.push_back(it);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [25:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bis_pkg::CFG_SRC_WIDTH:  src_w_reg   = val[9:0];
            bis_pkg::CFG_SRC_HEIGHT: src_h_reg   = val[9:0];
            bis_pkg::CFG_DST_WIDTH:  dst_w_reg   = val[10:0];
            bis_pkg::CFG_DST_HEIGHT: dst_h_reg   = val[10:0];
            bis_pkg::CFG_RATIO_X:    ratio_x_reg = val;
            bis_pkg::CFG_RATIO_Y:    ratio_y_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(int sw, int sh, int dw, int dh, int rx, int ry);
        cfg_write(bis_pkg::CFG_SRC_WIDTH, 26'(sw));
        cfg_write(bis_pkg::CFG_SRC_HEIGHT, 26'(sh));
        cfg_write(bis_pkg::CFG_DST_WIDTH, 26'(dw));
        cfg_write(bis_pkg::CFG_DST_HEIGHT, 26'(dh));
        cfg_write(bis_pkg::CFG_RATIO_X, 26'(rx));
        cfg_write(bis_pkg::CFG_RATIO_Y, 26'(ry));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int n);
        int roll, dw, dh;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            dw   = dst_eff(dst_w_reg);
            dh   = dst_eff(dst_h_reg);
            if (roll < 60 && dw > 0 && dh > 0)
                add_compute($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
            else if (roll < 75)
                add_compute($urandom_range(0, 1023), $urandom_range(0, 1023));
            else if (roll < 88)
                add_store($urandom_range(0, eff_size(int'(src_w_reg), FRAME_W) - 1),
                          $urandom_range(0, eff_size(int'(src_h_reg), FRAME_H) - 1),
                          8'($urandom), 8'($urandom), 8'($urandom));
            else
                add_store($urandom_range(0, 1023), $urandom_range(0, 1023),
                          8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req      <= pending_reqs.pop_front();
                start    <= 1'b1;
                gap_left  = next_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // transfer monitor and result checker
    always @(posedge clk)
    begin
        bis_pkg::res_t want;
        took <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $time, result);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_field("out_x", want.out_x, result.out_x);
                compare_field("out_y", want.out_y, result.out_y);
                compare_field("out_red", 10'(want.out_red), 10'(result.out_red));
                compare_field("out_green", 10'(want.out_green), 10'(result.out_green));
                compare_field("out_blue", 10'(want.out_blue), 10'(result.out_blue));
                compare_field("out_of_range", 10'(want.out_of_range),
                              10'(result.out_of_range));
            end
        end
        if (rst_n && start && !busy)
        begin
            if (req.req_type == bis_pkg::REQ_STORE)
            begin
                if (req.pos_x < FRAME_W && req.pos_y < FRAME_H)
                    frame_pix[req.pos_y * FRAME_W + req.pos_x] =
                        {req.in_blue, req.in_green, req.in_red};
            end
            else
                expected_pixels.push_back(predict_pixel(req));
        end
    end

    // watchdog: cycles with work outstanding but no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)
            || !(start || cfg_valid || pending_reqs.size() != 0
                 || expected_pixels.size() != 0))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int sw, sh, dw, dh;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, ignored stores, edge and outside requests
        add_store(0, 0, 8'h00, 8'h00, 8'h00);
        add_store(511, 511, 8'hFF, 8'hFF, 8'hFF);
        add_store(1, 0, 8'hFF, 8'h00, 8'hFF);
        add_store(1023, 3, 8'h12, 8'h34, 8'h56);
        add_store(3, 1023, 8'h65, 8'h43, 8'h21);
        add_compute(0, 0);
        add_compute(479, 639);
        add_compute(240, 320);
        add_compute(1, 1);
        add_compute(480, 0);
        add_compute(0, 640);
        add_compute(1023, 1023);
        wait_idle();

        sw = $urandom_range(1, 16);
        sh = $urandom_range(1, 16);
        dw = $urandom_range(1, 32);
        dh = $urandom_range(1, 32);
        set_config(sw, sh, dw, dh, sw * 65536 / dw, sh * 65536 / dh);
        run_random(80);
        wait_idle();

        // single source pixel, largest destination, no idle gaps
        set_config(1, 1, 1024, 1024, 64, 64);
        dense = 1'b1;
        run_random(60);
        wait_idle();
        dense = 1'b0;

        // zero source sizes saturate to one
        set_config(0, 0, $urandom_range(1, 8), $urandom_range(1, 8), 33554432,
                   $urandom_range(0, RATIO_MAX));
        run_random(40);
        wait_idle();

        // zero destination width: every request out of range
        cfg_write(CFG_SPARE_LO, 26'($urandom_range(0, RATIO_MAX)));
        cfg_write(CFG_SPARE_HI, 26'($urandom_range(0, RATIO_MAX)));
        set_config(1023, 512, 0, 1024, RATIO_MAX, 0);
        run_random(30);
        wait_idle();

        // oversized sizes saturate; columns run past the source and clamp
        set_config(1023, 512, 2047, 1024, RATIO_MAX, 0);
        run_random(80);
        wait_idle();

        set_config(512, 1, $urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(0, RATIO_MAX), $urandom_range(0, 1 << 17));
        run_random(60);
        wait_idle();

        sw = $urandom_range(1, 512);
        sh = $urandom_range(1, 512);
        dw = $urandom_range(1, 1024);
        dh = $urandom_range(1, 1024);
        set_config(sw, sh, dw, dh, sw * 65536 / dw, sh * 65536 / dh);
        run_random(80);
        wait_idle();

        sw = $urandom_range(2, 24);
        sh = $urandom_range(2, 24);
        dw = $urandom_range(1, 64);
        dh = $urandom_range(1, 64);
        set_config(sw, sh, dw, dh, sw * 65536 / dw, sh * 65536 / dh);
        run_random(80);
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
hdl/bis_pkg.sv
hdl/bis_map.sv
hdl/bis_frame.sv
hdl/bis_blend.sv
hdl/bilinear_image_scaler.sv
tb/bilinear_image_scaler_tb.sv
